>>> sv/pstth_pkg.sv
// ----------------------------------------------------------------------------
// pstth_pkg: shared types and constants for the per-source TTL histogram
// Table sizing, payload structs, controller/datapath handshake structs and
// the counter helper functions.
// ----------------------------------------------------------------------------
package pstth_pkg;

  localparam int unsigned ENTRIES    = 128;
  localparam int unsigned TTL_BINS   = 256;
  localparam int unsigned COUNT_BITS = 32;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned TTL_W     = 8;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W    = $clog2(ENTRIES + 1);
  localparam int unsigned BIN_W     = $clog2(TTL_BINS);
  localparam int unsigned CNT_DEPTH = ENTRIES * TTL_BINS;
  localparam int unsigned CADDR_W   = $clog2(CNT_DEPTH);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RMISS = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] src_addr;
    logic [TTL_W-1:0] ttl;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [OUT_W-1:0] bin_count;
  } out_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;     // clearing pass write
    logic start;   // latch item, restart scan
    logic scan;    // key scan active
    logic cnt_rd;  // read counter of matched entry
    logic upd;     // finish a hit: write back (record only) and load result
    logic miss;    // finish a miss: append or drop, load result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic miss_done;
    logic out_free;
  } dp_stat_t;

  function automatic count_t sat_inc(count_t c);
    count_t r;
    if (c == '1) begin
      r = c;
    end else begin
      r = c + count_t'(1);
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] report(count_t c);
    logic [63:0] w;
    logic [OUT_W-1:0] r;
    w = 64'(c);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      r = '1;
    end else begin
      r = w[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CADDR_W-1:0] caddr(logic [IDX_W-1:0] idx,
                                               logic [BIN_W-1:0] bin);
    logic [IDX_W+BIN_W-1:0] a;
    a = {idx, bin};
    return a[CADDR_W-1:0];
  endfunction

endpackage

>>> sv/per_source_ttl_histogram.sv
// ----------------------------------------------------------------------------
// per_source_ttl_histogram: TTL histogram per IPv4 source address
// Records packet TTLs into a per-address table of saturating bin counters
// and reads single bins back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one command per
//   transfer: record a TTL for a source address, or read one bin back.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   status and bin count per command, in order.
//   Addresses are found by scanning the key RAM one entry per cycle; on a
//   miss the scan covers every entry in use. One item is in flight at a
//   time; in_ready_o is high only while the block waits for a command.
//   After reset the counter RAM is swept to zero, with in_ready_o held low;
//   the table starts empty.
//   Results sit in an output register: a stalled receiver holds the result
//   while the next command is taken and scanned; the block then waits
//   before loading the next result.
// ----------------------------------------------------------------------------
module per_source_ttl_histogram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pstth_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pstth_pkg::out_t  out_data_o
);

  pstth_pkg::ctrl_cmd_t cmd;
  pstth_pkg::dp_stat_t  stat;

  pstth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pstth_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/pstth_ram.sv
// ----------------------------------------------------------------------------
// pstth_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pstth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pstth_ctrl.sv
// ----------------------------------------------------------------------------
// pstth_ctrl: sequencing state machine
// Clearing pass after reset, then accept / key scan / counter update.
// ----------------------------------------------------------------------------
module pstth_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pstth_pkg::dp_stat_t    stat_i,
  output pstth_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_UPD   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.cnt_rd = 1'b1;
          state_d      = S_UPD;
        end else if (stat_i.miss_done && stat_i.out_free) begin
          cmd_o.miss = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/pstth_dp.sv
// ----------------------------------------------------------------------------
// pstth_dp: key table, counter memory and result register
// Keys are scanned one per cycle through a pipelined RAM read; counters are
// updated by read-modify-write.
// ----------------------------------------------------------------------------
module pstth_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pstth_pkg::in_t         in_data_i,
  input  pstth_pkg::ctrl_cmd_t   cmd_i,
  output pstth_pkg::dp_stat_t    stat_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output pstth_pkg::out_t        out_data_o
);

  pstth_pkg::in_t                       item_q;
  logic [pstth_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [pstth_pkg::FILL_W-1:0]         scan_q, scan_d;
  logic                                 pend_q;
  logic [pstth_pkg::IDX_W-1:0]          pend_idx_q;
  logic [pstth_pkg::IDX_W-1:0]          slot_q;
  logic [pstth_pkg::CADDR_W-1:0]        clr_q;
  logic                                 out_valid_q, out_valid_d;
  pstth_pkg::out_t                      out_q, out_d;

  logic                                 issue;
  logic                                 full;
  logic                                 create;
  logic                                 is_rec;
  logic [pstth_pkg::BIN_W-1:0]          bin;
  logic [pstth_pkg::KEY_W-1:0]          key_rd;
  pstth_pkg::count_t                    cnt_rd;
  pstth_pkg::count_t                    cnt_inc;
  logic                                 cnt_we;
  logic [pstth_pkg::CADDR_W-1:0]        cnt_waddr;
  pstth_pkg::count_t                    cnt_wdata;

  assign bin     = item_q.ttl[pstth_pkg::BIN_W-1:0];
  assign is_rec  = (item_q.command == pstth_pkg::CMD_RECORD);
  assign full    = (fill_q == pstth_pkg::FILL_W'(pstth_pkg::ENTRIES));
  assign issue   = cmd_i.scan && (scan_q < fill_q);
  assign create  = cmd_i.miss && is_rec && !full;
  assign cnt_inc = pstth_pkg::sat_inc(cnt_rd);

  pstth_ram #(
    .WIDTH (pstth_pkg::KEY_W),
    .DEPTH (pstth_pkg::ENTRIES)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (create),
    .waddr_i (fill_q[pstth_pkg::IDX_W-1:0]),
    .wdata_i (item_q.src_addr),
    .re_i    (issue),
    .raddr_i (scan_q[pstth_pkg::IDX_W-1:0]),
    .rdata_o (key_rd)
  );

  // write port shared by the clearing pass, new entries and hit updates
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_q;
    cnt_wdata = '0;
    if (cmd_i.clr) begin
      cnt_we = 1'b1;
    end else if (create) begin
      cnt_we    = 1'b1;
      cnt_waddr = pstth_pkg::caddr(fill_q[pstth_pkg::IDX_W-1:0], bin);
      cnt_wdata = pstth_pkg::count_t'(1);
    end else if (cmd_i.upd && is_rec) begin
      cnt_we    = 1'b1;
      cnt_waddr = pstth_pkg::caddr(slot_q, bin);
      cnt_wdata = cnt_inc;
    end
  end

  pstth_ram #(
    .WIDTH (pstth_pkg::COUNT_BITS),
    .DEPTH (pstth_pkg::CNT_DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.cnt_rd),
    .raddr_i (pstth_pkg::caddr(pend_idx_q, bin)),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.start) begin
      scan_d = '0;
    end else if (issue) begin
      scan_d = scan_q + pstth_pkg::FILL_W'(1);
    end
  end

  assign fill_d = create ? fill_q + pstth_pkg::FILL_W'(1) : fill_q;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.upd) begin
      out_valid_d   = 1'b1;
      out_d.status  = pstth_pkg::ST_HIT;
      out_d.bin_count = is_rec ? pstth_pkg::report(cnt_inc) : pstth_pkg::report(cnt_rd);
    end else if (cmd_i.miss) begin
      out_valid_d     = 1'b1;
      out_d.bin_count = '0;
      if (!is_rec) begin
        out_d.status = pstth_pkg::ST_RMISS;
      end else if (full) begin
        out_d.status = pstth_pkg::ST_FULL;
      end else begin
        out_d.status    = pstth_pkg::ST_NEW;
        out_d.bin_count = pstth_pkg::OUT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      pend_q      <= issue;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr) begin
        clr_q <= clr_q + pstth_pkg::CADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_data_i;
    end
    pend_idx_q <= scan_q[pstth_pkg::IDX_W-1:0];
    if (cmd_i.cnt_rd) begin
      slot_q <= pend_idx_q;
    end
    out_q <= out_d;
  end

  assign stat_o.clr_last  = (clr_q == pstth_pkg::CADDR_W'(pstth_pkg::CNT_DEPTH - 1));
  assign stat_o.hit       = pend_q && (key_rd == item_q.src_addr);
  assign stat_o.miss_done = !pend_q && !(scan_q < fill_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/pstth_checker.sv
// ----------------------------------------------------------------------------
// pstth_checker: port-level checks for the TTL histogram
// Handshake stability and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module pstth_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  pstth_pkg::in_t   in_data_i,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  pstth_pkg::out_t  out_data_o
);

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // only one command in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken while another is in flight");

  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == pstth_pkg::ST_NEW)
    |-> out_data_o.bin_count == 32'd1)
    else $error("new entry must report a count of one");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == pstth_pkg::ST_FULL) ||
                    (out_data_o.status == pstth_pkg::ST_RMISS))
    |-> out_data_o.bin_count == 32'd0)
    else $error("drop or read miss must report zero");

endmodule

bind per_source_ttl_histogram pstth_checker u_pstth_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: per-source TTL histogram
// Sends record and read commands over the valid/ready input and keeps its own
// model of the address table and bin counters. It predicts each status and
// bin count and checks every result transfer in order. Both sides idle at
// random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_SIZE = 96;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  pstth_pkg::in_t  in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  pstth_pkg::out_t out_data_o;

  per_source_ttl_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // model of the address table and its histograms
  logic [pstth_pkg::KEY_W-1:0] key_tbl [pstth_pkg::ENTRIES];
  logic                        key_used [pstth_pkg::ENTRIES];
  int unsigned                 keys_in_use;
  pstth_pkg::count_t           bin_tbl [pstth_pkg::ENTRIES][pstth_pkg::TTL_BINS];

  pstth_pkg::out_t             pending_results [$];
  logic [pstth_pkg::KEY_W-1:0] addr_pool [POOL_SIZE];
  int unsigned                 mismatches  = 0;
  int unsigned                 hold_cycles = 0;
  bit                          no_idle     = 1'b0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : run_limit
    #(10_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  // Applies one command to the table model and returns the result it gives.
  function automatic pstth_pkg::out_t histogram_update(pstth_pkg::in_t item);
    int                slot;
    pstth_pkg::count_t c;
    pstth_pkg::out_t   r;
    slot = -1;
    c    = '0;
    for (int i = 0; i < pstth_pkg::ENTRIES; i++) begin
      if (key_used[i] && key_tbl[i] == item.src_addr) begin
        slot = i;
        break;
      end
    end
    r.status = pstth_pkg::ST_HIT;
    if (item.command == pstth_pkg::CMD_READ) begin
      if (slot < 0) begin
        r.status = pstth_pkg::ST_RMISS;
      end else begin
        c = bin_tbl[slot][item.ttl];
      end
    end else if (slot >= 0) begin
      if (bin_tbl[slot][item.ttl] != '1) begin
        bin_tbl[slot][item.ttl] = bin_tbl[slot][item.ttl] + pstth_pkg::count_t'(1);
      end
      c = bin_tbl[slot][item.ttl];
    end else if (keys_in_use >= pstth_pkg::ENTRIES) begin
      r.status = pstth_pkg::ST_FULL;
    end else begin
      key_tbl[keys_in_use]  = item.src_addr;
      key_used[keys_in_use] = 1'b1;
      for (int b = 0; b < pstth_pkg::TTL_BINS; b++) begin
        bin_tbl[keys_in_use][b] = '0;
      end
      bin_tbl[keys_in_use][item.ttl] = pstth_pkg::count_t'(1);
      keys_in_use = keys_in_use + 1;
      r.status = pstth_pkg::ST_NEW;
      c = pstth_pkg::count_t'(1);
    end
    // wide counters are reported clipped to the output width
    r.bin_count = (64'(c) > 64'h0000_0000_FFFF_FFFF) ? '1 : pstth_pkg::OUT_W'(c);
    return r;
  endfunction

  task automatic send_cmd(pstth_pkg::cmd_e cmd, logic [pstth_pkg::KEY_W-1:0] addr,
                          logic [pstth_pkg::TTL_W-1:0] ttl);
    pstth_pkg::in_t item;
    int unsigned    gap;
    item.command  = cmd;
    item.src_addr = addr;
    item.ttl      = ttl;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(histogram_update(item));
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: draws a stall after each transfer, and honours long hold-offs
  initial begin : result_check
    pstth_pkg::out_t want;
    int unsigned     stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall = stall - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d count %0d", $time,
                   out_data_o.status, out_data_o.bin_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time,
                     want.status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.bin_count !== want.bin_count) begin
            $display("%0t: bin_count expected %0d, got %0d", $time,
                     want.bin_count, out_data_o.bin_count);
            mismatches++;
          end
        end
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
    end
  end

  task automatic test_directed();
    send_cmd(pstth_pkg::CMD_READ,   32'h0000_0000, 8'h00);  // empty table: read misses
    send_cmd(pstth_pkg::CMD_READ,   32'hFFFF_FFFF, 8'hFF);
    send_cmd(pstth_pkg::CMD_RECORD, 32'h0000_0000, 8'h00);  // new entry
    send_cmd(pstth_pkg::CMD_RECORD, 32'h0000_0000, 8'h00);  // hit
    send_cmd(pstth_pkg::CMD_RECORD, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   32'hFFFF_FFFF, 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   32'hFFFF_FFFF, 8'h00);  // known address, empty bin
    send_cmd(pstth_pkg::CMD_RECORD, 32'hFFFF_FFFF, 8'h00);
    send_cmd(pstth_pkg::CMD_READ,   32'h0000_0000, 8'h00);
    send_cmd(pstth_pkg::CMD_RECORD, 32'hA5A5_A5A5, 8'h55);
    send_cmd(pstth_pkg::CMD_RECORD, 32'h5A5A_5A5A, 8'hAA);
    send_cmd(pstth_pkg::CMD_READ,   32'hA5A5_A5A5, 8'hAA);
    send_cmd(pstth_pkg::CMD_READ,   32'h5A5A_5A5B, 8'hAA);  // one bit off a stored key
    send_cmd(pstth_pkg::CMD_RECORD, 32'h0000_0000, 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   32'h0000_0000, 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   32'h5A5A_5A5A, 8'hAA);
    wait_results_done();
  endtask

  // mostly a fixed set of sources, so bins build up; a few strangers
  task automatic test_random_pool(int unsigned n);
    int unsigned                 pick;
    logic [pstth_pkg::KEY_W-1:0] addr;
    logic [pstth_pkg::TTL_W-1:0] ttl;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      addr = (pick < 94) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
      ttl  = pstth_pkg::TTL_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                    : $urandom_range(60, 66));
      send_cmd((pick % 3 == 0) ? pstth_pkg::CMD_READ : pstth_pkg::CMD_RECORD, addr, ttl);
    end
    no_idle = 1'b0;
    wait_results_done();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    hold_cycles = 400;
    for (int k = 0; k < 12; k++) begin
      send_cmd(k[0] ? pstth_pkg::CMD_READ : pstth_pkg::CMD_RECORD, addr_pool[k], 8'd64);
    end
    wait_results_done();
  endtask

  task automatic test_fill_table();
    while (keys_in_use < pstth_pkg::ENTRIES) begin
      send_cmd(pstth_pkg::CMD_RECORD, $urandom,
               pstth_pkg::TTL_W'($urandom_range(0, 255)));
    end
    send_cmd(pstth_pkg::CMD_RECORD, 32'h0BAD_0001, 8'd7);   // dropped, table full
    send_cmd(pstth_pkg::CMD_READ,   32'h0BAD_0001, 8'd7);
    // last slot, longest scan
    send_cmd(pstth_pkg::CMD_RECORD, key_tbl[pstth_pkg::ENTRIES-1], 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   key_tbl[pstth_pkg::ENTRIES-1], 8'hFF);
    send_cmd(pstth_pkg::CMD_READ,   key_tbl[0], 8'h00);
    wait_results_done();
  endtask

  task automatic test_full_table(int unsigned n);
    int unsigned                 pick;
    logic [pstth_pkg::KEY_W-1:0] addr;
    logic [pstth_pkg::TTL_W-1:0] ttl;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      addr = (pick < 60) ? key_tbl[$urandom_range(0, pstth_pkg::ENTRIES - 1)] : $urandom;
      ttl  = pstth_pkg::TTL_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                    : $urandom_range(60, 66));
      send_cmd(pick[0] ? pstth_pkg::CMD_READ : pstth_pkg::CMD_RECORD, addr, ttl);
    end
    no_idle = 1'b0;
    wait_results_done();
  endtask

  initial begin : main_sequence
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    keys_in_use = 0;
    for (int i = 0; i < pstth_pkg::ENTRIES; i++) begin
      key_used[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = $urandom;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_pool(600);
    test_output_stall();
    test_fill_table();
    test_full_table(750);

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pstth_pkg.sv
sv/pstth_ram.sv
sv/pstth_ctrl.sv
sv/pstth_dp.sv
sv/per_source_ttl_histogram.sv
sv/pstth_checker.sv
tb/testbench.sv
